### design/rpfl_pkg.sv
// ----------------------------------------------------------------------------
// rpfl_pkg - shared definitions for the page free list
// Sizes, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package rpfl_pkg;

  // Store sizes
  localparam int NUM_PAGES   = 4096;
  localparam int COUNT_WIDTH = 8;
  localparam int ADDR_W      = $clog2(NUM_PAGES);
  localparam int PAGE_W      = 12;
  localparam int LINK_W      = PAGE_W + 1;

  // Request kinds (carried on s_tuser)
  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  // Result status (carried on m_tuser)
  typedef enum logic [2:0] {
    ST_ALLOCATED     = 3'd0,
    ST_OUT_OF_MEMORY = 3'd1,
    ST_PUSHED        = 3'd2,
    ST_DROPPED       = 3'd3,
    ST_BAD_PAGE      = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_WAIT,
    S_FREE_WAIT
  } state_t;

endpackage

### design/refcounted_page_free_list.sv
// Page frame allocator: a last-in-first-out free list threaded through a
// next-link memory, with a reference count memory beside it. After reset the
// block sweeps all NUM_PAGES (4096) entries of the count memory to zero, one
// entry a cycle, and holds s_tready low meanwhile; configuration writes are
// taken throughout. An allocate on an empty list and a free of a bad page
// load their result straight from the idle state; every other word passes
// through a wait state, because the popped page's next link (allocate) or the
// page's count (free) comes out of a registered memory read before the head or
// count can be updated. The result sits in an output register, so a new word
// is taken in the same cycle as the last result leaves; no new word is taken
// during a wait state, and short cases run one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
// refcounted_page_free_list - page allocator with reference counts
// Allocate pops the list head and sets its count to one; free drops the count
// (saturating at zero) and pushes the page once the count is zero.
// ----------------------------------------------------------------------------
module refcounted_page_free_list (
  input  logic        clk,
  input  logic        rst,
  // configuration: first_usable_page
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] page_number, [15:12] zero
  input  logic        s_tuser,   // [0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [11:0] granted_page, [15:12] zero
  output logic [2:0]  m_tuser    // [2:0] status
);

  localparam int AW = rpfl_pkg::ADDR_W;
  localparam int PW = rpfl_pkg::PAGE_W;
  localparam int CW = rpfl_pkg::COUNT_WIDTH;
  localparam int LW = rpfl_pkg::LINK_W;

  // Memories
  logic [CW-1:0] count_mem [rpfl_pkg::NUM_PAGES];
  logic [LW-1:0] link_mem  [rpfl_pkg::NUM_PAGES];

  // Control state
  rpfl_pkg::state_t state, state_next;
  logic [AW-1:0]    clr_addr;
  logic [PW-1:0]    first_usable_page;
  logic [PW-1:0]    list_head;
  logic             list_empty;
  logic [PW-1:0]    item_page;

  // Output register
  logic                m_valid;
  rpfl_pkg::status_t   out_status;
  logic [PW-1:0]       out_page;

  // Memory ports
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [AW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_rdata;
  logic          lnk_we;
  logic [AW-1:0] lnk_waddr;
  logic [LW-1:0] lnk_wdata;
  logic [LW-1:0] lnk_rdata;

  // Combinational controls
  logic              accept;
  logic              in_page_bad;
  logic [PW-1:0]     in_page;
  logic [CW-1:0]     cnt_dec;
  logic              load_out;
  rpfl_pkg::status_t load_status;
  logic [PW-1:0]     load_page;
  logic              head_pop;
  logic              head_push;

  assign in_page  = s_tdata[PW-1:0];
  assign s_tready = (state == rpfl_pkg::S_IDLE) && (!m_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // Page below the kernel image limit or beyond the store
  assign in_page_bad = (in_page < first_usable_page) ||
                       ({1'b0, in_page} >= (PW + 1)'(rpfl_pkg::NUM_PAGES));

  // Saturating decrement of the fetched count
  assign cnt_dec = (cnt_rdata != '0) ? cnt_rdata - CW'(1) : '0;

  assign cnt_raddr = in_page[AW-1:0];

  // Next state, memory writes and result load
  always_comb begin
    state_next  = state;
    cnt_we      = 1'b0;
    cnt_waddr   = clr_addr;
    cnt_wdata   = '0;
    lnk_we      = 1'b0;
    lnk_waddr   = item_page[AW-1:0];
    lnk_wdata   = list_empty ? LW'(1) << PW : {1'b0, list_head};
    load_out    = 1'b0;
    load_status = rpfl_pkg::ST_BAD_PAGE;
    load_page   = '0;
    head_pop    = 1'b0;
    head_push   = 1'b0;
    case (state)
      rpfl_pkg::S_CLEAR: begin
        cnt_we = 1'b1;
        if (clr_addr == AW'(rpfl_pkg::NUM_PAGES - 1)) begin
          state_next = rpfl_pkg::S_IDLE;
        end
      end
      rpfl_pkg::S_IDLE: begin
        if (accept) begin
          if (s_tuser == rpfl_pkg::KIND_ALLOC) begin
            if (list_empty) begin
              load_out    = 1'b1;
              load_status = rpfl_pkg::ST_OUT_OF_MEMORY;
            end else begin
              // claim the head page now; its link is read this cycle
              cnt_we     = 1'b1;
              cnt_waddr  = list_head[AW-1:0];
              cnt_wdata  = CW'(1);
              state_next = rpfl_pkg::S_ALLOC_WAIT;
            end
          end else begin
            if (in_page_bad) begin
              load_out    = 1'b1;
              load_status = rpfl_pkg::ST_BAD_PAGE;
            end else begin
              state_next = rpfl_pkg::S_FREE_WAIT;
            end
          end
        end
      end
      rpfl_pkg::S_ALLOC_WAIT: begin
        head_pop    = 1'b1;
        load_out    = 1'b1;
        load_status = rpfl_pkg::ST_ALLOCATED;
        load_page   = item_page;
        state_next  = rpfl_pkg::S_IDLE;
      end
      rpfl_pkg::S_FREE_WAIT: begin
        cnt_we     = 1'b1;
        cnt_waddr  = item_page[AW-1:0];
        cnt_wdata  = cnt_dec;
        load_out   = 1'b1;
        state_next = rpfl_pkg::S_IDLE;
        if (cnt_dec == '0) begin
          lnk_we      = 1'b1;
          head_push   = 1'b1;
          load_status = rpfl_pkg::ST_PUSHED;
        end else begin
          load_status = rpfl_pkg::ST_DROPPED;
        end
      end
      default: begin
        state_next = rpfl_pkg::S_CLEAR;
      end
    endcase
  end

  // State register and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rpfl_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == rpfl_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable_page <= '0;
    end else if (cfg_we) begin
      first_usable_page <= cfg_wdata;
    end
  end

  // List head
  always_ff @(posedge clk) begin
    if (rst) begin
      list_head  <= '0;
      list_empty <= 1'b1;
    end else if (head_pop) begin
      list_empty <= lnk_rdata[PW];
      list_head  <= lnk_rdata[PW] ? '0 : lnk_rdata[PW-1:0];
    end else if (head_push) begin
      list_empty <= 1'b0;
      list_head  <= item_page;
    end
  end

  // Page of the word in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      item_page <= (s_tuser == rpfl_pkg::KIND_ALLOC) ? list_head : in_page;
    end
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= count_mem[cnt_raddr];
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (lnk_we) begin
      link_mem[lnk_waddr] <= lnk_wdata;
    end
    lnk_rdata <= link_mem[list_head[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_out) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= load_status;
      out_page   <= load_page;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {(16 - PW)'(0), out_page};

  // Checks
  // an empty list always carries a cleared head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    list_empty |-> (list_head == '0))
    else $error("empty list with non-zero head");

  // only a grant carries a page number
  a_grant_page: assert property (@(posedge clk) disable iff (rst)
    (m_valid && (out_status != rpfl_pkg::ST_ALLOCATED)) |-> (out_page == '0))
    else $error("page number on a non-grant result");

  // an accepted word either has its result up or is still at work
  a_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (m_valid || (state == rpfl_pkg::S_ALLOC_WAIT) ||
                (state == rpfl_pkg::S_FREE_WAIT)))
    else $error("accepted word lost");

  // a grant always leaves the granted page with a count of one
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    (state == rpfl_pkg::S_ALLOC_WAIT) |-> $past(cnt_we && (cnt_wdata == CW'(1))))
    else $error("grant without count set");

endmodule
